// File: hdl/ket_pkg.sv
// Shared types and codes for the keyed entry table.
package ket_pkg;

   localparam int KEY_BITS      = 32;
   localparam int NAME_IO_BITS  = 64;
   localparam int CAP_BITS      = 7;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_GET    = 2'd2,
      CMD_UPDATE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_ADD_DUP  = 3'd2,
      ST_DEL_MISS = 3'd3,
      ST_GET_MISS = 3'd4,
      ST_UPD_MISS = 3'd5,
      ST_UPD_DUP  = 3'd6
   } status_type;

   typedef struct packed {
      cmd_type                        cmd;
      logic signed [KEY_BITS-1:0]     key;
      logic signed [KEY_BITS-1:0]     new_key;
      logic [NAME_IO_BITS-1:0]        name_value;
   } req_type;

   typedef struct packed {
      status_type                     status;
      logic signed [KEY_BITS-1:0]     found_key;
      logic [NAME_IO_BITS-1:0]        found_name;
   } rsp_type;

endpackage

// File: hdl/ket_ram.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
module ket_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/ket_seq.sv
// Request sequencer: linear search, delete compaction, write-back and result register.
module ket_seq
   import ket_pkg::*;
#(
   parameter int DEPTH     = 64,
   parameter int NAME_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [CAP_BITS-1:0]      capacity,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req,
   output logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic [KEY_BITS-1:0]      key_rd,
   input  logic [NAME_BITS-1:0]     name_rd,
   output logic                     wr_en,
   output logic [$clog2(DEPTH)-1:0] wr_addr,
   output logic [KEY_BITS-1:0]      wr_key,
   output logic [NAME_BITS-1:0]     wr_name,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > CAP_BITS) ? CW : CAP_BITS;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   req_type                   req_ff, req_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]             chk_ptr_ff, chk_ptr_in;
   logic [AW-1:0]             slot_ff, slot_in;
   logic                      hit_ff, hit_in;
   logic                      dup_ff, dup_in;
   logic                      full_ff, full_in;
   logic [KEY_BITS-1:0]       hit_key_ff, hit_key_in;
   logic [NAME_BITS-1:0]      hit_name_ff, hit_name_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic accept;
   logic take;
   logic at_limit;
   logic match_key;
   logic match_new;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign take      = rsp_valid_ff && !rsp_stall;
   assign at_limit  = (LW'(count_ff) >= LW'(capacity)) || (count_ff == CW'(DEPTH));
   assign match_key = (key_rd == req_ff.key);
   assign match_new = (key_rd == req_ff.new_key) && (req_ff.new_key != req_ff.key);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      chk_ptr_in   = chk_ptr_ff;
      slot_in      = slot_ff;
      hit_in       = hit_ff;
      dup_in       = dup_ff;
      full_in      = full_ff;
      hit_key_in   = hit_key_ff;
      hit_name_in  = hit_name_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rd_addr      = rd_ptr_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = chk_ptr_ff - AW'(1);
      wr_key       = key_rd;
      wr_name      = name_rd;

      if (take) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (accept) begin
               req_in     = req;
               hit_in     = 1'b0;
               dup_in     = 1'b0;
               full_in    = (req.cmd == CMD_ADD) && at_limit;
               rd_ptr_in  = CW'(1);
               chk_ptr_in = '0;
               if (count_ff == '0 || ((req.cmd == CMD_ADD) && at_limit)) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // keys are unique, so at most one entry matches key
            if (match_key) begin
               hit_in      = 1'b1;
               slot_in     = chk_ptr_ff;
               hit_key_in  = key_rd;
               hit_name_in = name_rd;
            end
            if (match_new) begin
               dup_in = 1'b1;
            end
            // shift each entry after the deleted one down by a slot
            if (hit_ff && req_ff.cmd == CMD_DELETE) begin
               wr_en = 1'b1;
            end
            if (rd_ptr_ff < count_ff) begin
               chk_ptr_in = rd_ptr_ff[AW-1:0];
               rd_ptr_in  = rd_ptr_ff + CW'(1);
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || take) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = ST_OK;
               rsp_in.found_key  = '0;
               rsp_in.found_name = '0;
               state_in          = S_IDLE;
               case (req_ff.cmd)
                  CMD_ADD: begin
                     if (full_ff) begin
                        rsp_in.status = ST_FULL;
                     end else if (hit_ff) begin
                        rsp_in.status = ST_ADD_DUP;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_key   = req_ff.key;
                        wr_name  = req_ff.name_value[NAME_BITS-1:0];
                        count_in = count_ff + CW'(1);
                     end
                  end
                  CMD_DELETE: begin
                     if (!hit_ff) begin
                        rsp_in.status = ST_DEL_MISS;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  CMD_GET: begin
                     if (!hit_ff) begin
                        rsp_in.status = ST_GET_MISS;
                     end else begin
                        rsp_in.found_key  = $signed(hit_key_ff);
                        rsp_in.found_name = NAME_IO_BITS'(hit_name_ff);
                     end
                  end
                  CMD_UPDATE: begin
                     if (dup_ff) begin
                        rsp_in.status = ST_UPD_DUP;
                     end else if (!hit_ff) begin
                        rsp_in.status = ST_UPD_MISS;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = slot_ff;
                        wr_key  = req_ff.new_key;
                        wr_name = req_ff.name_value[NAME_BITS-1:0];
                     end
                  end
                  default: begin
                     rsp_in.status = ST_OK;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      rd_ptr_ff   <= rd_ptr_in;
      chk_ptr_ff  <= chk_ptr_in;
      slot_ff     <= slot_in;
      hit_ff      <= hit_in;
      dup_ff      <= dup_in;
      full_ff     <= full_in;
      hit_key_ff  <= hit_key_in;
      hit_name_ff <= hit_name_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond table depth");

   a_count_on_finish: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> ($past(state_ff == S_FINISH) || $past(reset)))
      else $error("entry count changed outside request completion");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("result raised without a finished request");

   a_shift_no_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff == S_SCAN) |-> (wr_addr != rd_addr))
      else $error("compaction write hits the slot being read");

endmodule

// File: hdl/keyed_entry_table.sv
// Top level of the keyed entry table: capacity register, key and name memories, sequencer.
// An accepted request scans the entries held, and then its result is registered; the
//   scan is skipped when the table is empty or an add finds it full.
// A new request is taken only once the previous result is registered; the search walks
//   the single read port one slot a cycle, and delete compacts in the same walk.
// Reset (synchronous, active high) empties the table and sets capacity to 64.
module keyed_entry_table
   import ket_pkg::*;
#(
   parameter int DEPTH     = 64,
   parameter int NAME_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CAP_BITS-1:0]      csr_wr_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_cmd,
   input  logic signed [31:0]       req_key,
   input  logic signed [31:0]       req_new_key,
   input  logic [63:0]              req_name_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_status,
   output logic signed [31:0]       rsp_found_key,
   output logic [63:0]              rsp_found_name
);

   localparam int AW = $clog2(DEPTH);

   logic [CAP_BITS-1:0]  capacity_ff;
   req_type              req;
   rsp_type              rsp;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;
   logic                 wr_en;
   logic [KEY_BITS-1:0]  key_rd;
   logic [KEY_BITS-1:0]  wr_key;
   logic [NAME_BITS-1:0] name_rd;
   logic [NAME_BITS-1:0] wr_name;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   assign req.cmd        = cmd_type'(req_cmd);
   assign req.key        = req_key;
   assign req.new_key    = req_new_key;
   assign req.name_value = req_name_value;

   ket_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (DEPTH)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_key),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   ket_ram #(
      .WIDTH (NAME_BITS),
      .DEPTH (DEPTH)
   ) u_name_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_name),
      .rd_addr (rd_addr),
      .rd_data (name_rd)
   );

   ket_seq #(
      .DEPTH     (DEPTH),
      .NAME_BITS (NAME_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .capacity  (capacity_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rd_addr   (rd_addr),
      .key_rd    (key_rd),
      .name_rd   (name_rd),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_key    (wr_key),
      .wr_name   (wr_name),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_status     = rsp.status;
   assign rsp_found_key  = rsp.found_key;
   assign rsp_found_name = rsp.found_name;

endmodule

// File: test/keyed_entry_table_test.sv
// Self-checking testbench for the keyed entry table: add, delete, get and update.
module keyed_entry_table_test;
   import ket_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int LONG_HOLD   = 250;
   localparam int IDLE_LIMIT  = 2000;
   localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CAP_BITS-1:0]  csr_wr_data;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_cmd;
   logic signed [31:0]   req_key;
   logic signed [31:0]   req_new_key;
   logic [63:0]          req_name_value;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [2:0]           rsp_status;
   logic signed [31:0]   rsp_found_key;
   logic [63:0]          rsp_found_name;

   // own copy of the table contents
   logic signed [31:0]   held_keys[TABLE_DEPTH];
   logic [63:0]          held_names[TABLE_DEPTH];
   int                   held_count;
   int                   cap_setting;

   rsp_type              pending_outcomes[$];
   rsp_type              want;
   int                   error_count;
   int                   results_checked;
   int                   requests_sent;
   int                   cmd_seen[4];
   int                   status_seen[8];
   int                   idle_cycles;
   bit                   hold_rsp = 1'b0;
   bit                   quiet = 1'b0;

   keyed_entry_table #(
      .DEPTH     (TABLE_DEPTH),
      .NAME_BITS (64)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_key        (req_key),
      .req_new_key    (req_new_key),
      .req_name_value (req_name_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_found_key  (rsp_found_key),
      .rsp_found_name (rsp_found_name)
   );

   always #4 clock = ~clock;

   function automatic int slot_of(logic signed [31:0] k);
      for (int i = 0; i < held_count; i++) begin
         if (held_keys[i] == k) return i;
      end
      return -1;
   endfunction

   // apply one request to the table copy and return the result it should give
   function automatic rsp_type predict_outcome(req_type r);
      rsp_type res;
      int      slot;
      int      limit;
      bit      dup;
      res = '0;
      res.status = ST_OK;
      limit = (cap_setting < TABLE_DEPTH) ? cap_setting : TABLE_DEPTH;
      slot = slot_of(r.key);
      case (r.cmd)
         CMD_ADD: begin
            if (held_count >= limit) begin
               res.status = ST_FULL;
            end else if (slot >= 0) begin
               res.status = ST_ADD_DUP;
            end else begin
               held_keys[held_count]  = r.key;
               held_names[held_count] = r.name_value;
               held_count++;
            end
         end
         CMD_DELETE: begin
            if (slot < 0) begin
               res.status = ST_DEL_MISS;
            end else begin
               for (int i = slot; i < held_count - 1; i++) begin
                  held_keys[i]  = held_keys[i + 1];
                  held_names[i] = held_names[i + 1];
               end
               held_count--;
            end
         end
         CMD_GET: begin
            if (slot < 0) begin
               res.status = ST_GET_MISS;
            end else begin
               res.found_key  = held_keys[slot];
               res.found_name = held_names[slot];
            end
         end
         default: begin
            // the entry's own key does not count as a duplicate
            dup = 1'b0;
            for (int i = 0; i < held_count; i++) begin
               if (i != slot && held_keys[i] == r.new_key) dup = 1'b1;
            end
            if (dup) begin
               res.status = ST_UPD_DUP;
            end else if (slot < 0) begin
               res.status = ST_UPD_MISS;
            end else begin
               held_keys[slot]  = r.new_key;
               held_names[slot] = r.name_value;
            end
         end
      endcase
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // mostly keys already held, so that hits and duplicates are common
   function automatic logic signed [31:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60 && held_count > 0) return held_keys[$urandom_range(0, held_count - 1)];
      if (r < 80) return int'($urandom_range(0, 16)) - 8;
      if (r < 85) return (r % 2) ? KEY_MAX : KEY_MIN;
      return $urandom();
   endfunction

   task automatic send_request(cmd_type c, logic signed [31:0] k, logic signed [31:0] nk,
                               logic [63:0] nm);
      req_type r;
      int      gap;
      r.cmd = c;
      r.key = k;
      r.new_key = nk;
      r.name_value = nm;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= c;
      req_key        <= k;
      req_new_key    <= nk;
      req_name_value <= nm;
      do @(posedge clock); while (req_stall);
      pending_outcomes.push_back(predict_outcome(r));
      requests_sent++;
      cmd_seen[c]++;
   endtask

   // drop valid in the step of the last acceptance, then wait for every result
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_BITS-1:0] v);
      drain_results();
      csr_wr_data <= v;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cap_setting = v;
   endtask

   task automatic test_basic_commands();
      send_request(CMD_GET, KEY_MIN, 0, 64'd0);
      send_request(CMD_DELETE, KEY_MIN, 0, 64'd0);
      send_request(CMD_UPDATE, 0, 5, 64'd1);
      send_request(CMD_ADD, KEY_MIN, KEY_MAX, 64'd0);
      send_request(CMD_ADD, KEY_MAX, KEY_MIN, '1);
      send_request(CMD_ADD, 0, 0, 64'h0123_4567_89ab_cdef);
      send_request(CMD_ADD, -1, 0, 64'h8000_0000_0000_0001);
      send_request(CMD_ADD, KEY_MAX, 0, 64'h5555_5555_5555_5555);
      send_request(CMD_GET, KEY_MIN, 0, 64'd0);
      send_request(CMD_GET, KEY_MAX, 0, 64'd0);
      send_request(CMD_GET, -1, 0, 64'd0);
      send_request(CMD_UPDATE, -1, -1, 64'haaaa_aaaa_aaaa_aaaa);
      send_request(CMD_UPDATE, 0, KEY_MAX, 64'd2);
      // missing key but a clashing new key: duplicate wins
      send_request(CMD_UPDATE, 5, KEY_MIN, 64'd3);
      send_request(CMD_UPDATE, 5, 7, 64'd4);
      send_request(CMD_UPDATE, 0, 123, 64'hfeed_f00d_dead_beef);
      send_request(CMD_GET, 123, 0, 64'd0);
      send_request(CMD_GET, 0, 0, 64'd0);
      send_request(CMD_DELETE, KEY_MIN, 0, 64'd0);
      send_request(CMD_GET, -1, 0, 64'd0);
      send_request(CMD_DELETE, -1, 0, 64'd0);
      send_request(CMD_DELETE, 42, 0, 64'd0);
      send_request(CMD_GET, KEY_MAX, 0, 64'd0);
   endtask

   task automatic test_capacity_limits();
      write_capacity(7'd0);
      send_request(CMD_ADD, 11, 0, 64'd11);
      send_request(CMD_GET, KEY_MAX, 0, 64'd0);
      write_capacity(7'd1);
      while (held_count > 0) send_request(CMD_DELETE, held_keys[0], 0, 64'd0);
      send_request(CMD_ADD, 21, 0, 64'd21);
      send_request(CMD_ADD, 22, 0, 64'd22);
      // full is reported before the duplicate check
      send_request(CMD_ADD, 21, 0, 64'd21);
      write_capacity(7'd127);
      for (int i = 0; held_count < TABLE_DEPTH; i++) begin
         send_request(CMD_ADD, i * 1000003 - 7, 0, {$urandom(), $urandom()});
      end
      send_request(CMD_ADD, 99, 0, 64'd99);
      send_request(CMD_GET, held_keys[TABLE_DEPTH - 1], 0, 64'd0);
      send_request(CMD_UPDATE, held_keys[10], held_keys[40], 64'd7);
      send_request(CMD_DELETE, held_keys[0], 0, 64'd0);
      send_request(CMD_ADD, 99, 0, 64'd99);
      // lowered below the fill: entries stay, adds stay full
      write_capacity(7'd3);
      send_request(CMD_ADD, 5, 0, 64'd5);
      while (held_count > 2) send_request(CMD_DELETE, held_keys[held_count - 1], 0, 64'd0);
      send_request(CMD_ADD, 5, 0, 64'd5);
      send_request(CMD_ADD, 6, 0, 64'd6);
   endtask

   task automatic test_result_hold_off();
      drain_results();
      quiet = 1'b1;
      hold_rsp = 1'b1;
      for (int i = 0; i < 16; i++) begin
         send_request((i % 2) ? CMD_GET : CMD_ADD, pick_key(), 0, {$urandom(), $urandom()});
      end
      quiet = 1'b0;
   endtask

   task automatic test_random_mix(logic [CAP_BITS-1:0] cap, int count, int add_weight);
      int      r;
      cmd_type c;
      write_capacity(cap);
      for (int n = 0; n < count; n++) begin
         quiet = (n < 15);
         r = $urandom_range(0, 99);
         if (r < add_weight)           c = CMD_ADD;
         else if (r < add_weight + 20) c = CMD_DELETE;
         else if (r < add_weight + 45) c = CMD_GET;
         else                          c = CMD_UPDATE;
         send_request(c, pick_key(), pick_key(), {$urandom(), $urandom()});
      end
      quiet = 1'b0;
   endtask

   // result side: random stall, with one long hold-off on request
   initial begin
      int n;
      int r;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
            n = LONG_HOLD;
         end else if (quiet || r < 55) begin
            rsp_stall <= 1'b0;
            n = quiet ? 1 : $urandom_range(1, 6);
         end else begin
            rsp_stall <= 1'b1;
            n = (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
         end
         repeat (n) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         status_seen[rsp_status]++;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result: expected none, got status %0d key %0d name %h",
                     $time, rsp_status, rsp_found_key, rsp_found_name);
            error_count++;
         end else begin
            want = pending_outcomes.pop_front();
            results_checked++;
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch: expected %0d, got %0d",
                        $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_found_key !== want.found_key) begin
               $display("%0t: found_key mismatch: expected %0d, got %0d",
                        $time, want.found_key, rsp_found_key);
               error_count++;
            end
            if (rsp_found_name !== want.found_name) begin
               $display("%0t: found_name mismatch: expected %h, got %h",
                        $time, want.found_name, rsp_found_name);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, nothing moved for %0d cycles", $time, IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_valid      = 1'b0;
      req_cmd        = CMD_ADD;
      req_key        = '0;
      req_new_key    = '0;
      req_name_value = '0;
      held_count     = 0;
      cap_setting    = CAP_RESET;
      error_count    = 0;
      results_checked = 0;
      requests_sent  = 0;
      idle_cycles    = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_basic_commands();
      test_capacity_limits();
      test_result_hold_off();
      test_random_mix(7'd64, 53, 40);
      test_random_mix(7'd5, 53, 35);
      test_random_mix(7'd127, 53, 55);
      test_random_mix(7'd1, 53, 35);
      test_random_mix(7'd33, 53, 40);
      test_random_mix(7'd0, 53, 35);
      test_random_mix(7'd64, 53, 30);

      drain_results();
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      $display("Checked %0d results for %0d requests: add %0d, delete %0d, get %0d, update %0d",
               results_checked, requests_sent, cmd_seen[CMD_ADD], cmd_seen[CMD_DELETE],
               cmd_seen[CMD_GET], cmd_seen[CMD_UPDATE]);
      $display("Outcomes ok %0d, full %0d, add dup %0d, misses %0d/%0d/%0d, update dup %0d",
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_ADD_DUP],
               status_seen[ST_DEL_MISS], status_seen[ST_GET_MISS], status_seen[ST_UPD_MISS],
               status_seen[ST_UPD_DUP]);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: keyed_entry_table.f
hdl/ket_pkg.sv
hdl/ket_ram.sv
hdl/ket_seq.sv
hdl/keyed_entry_table.sv
test/keyed_entry_table_test.sv
